// ===== src/smid_pkg.sv =====
// Shared types, constants and helper functions for the sound-chip to MIDI event block.
package smid_pkg;

    localparam int CLK_W          = 48;
    localparam int RATE_W         = 22;
    localparam int NUM_W          = 58;
    localparam int PROD_W         = 38;
    localparam int TICK_W         = 32;
    localparam int DELTA_W        = 28;
    localparam int VIDX_W         = 2;
    localparam int CNT_W          = 6;
    localparam int REGS_PER_VOICE = 7;
    localparam int EDGE_W         = 28;

    localparam logic [RATE_W-1:0]  RATE_RESET     = 22'd985248;
    localparam logic [DELTA_W-1:0] DELTA_MAX      = '1;
    localparam logic [7:0]         NOTE_COUNT_TOP = 8'd129;
    localparam logic [CNT_W-1:0]   END_LAST_IDX   = 6'd3;
    localparam logic [CNT_W-1:0]   TEMPO_FIRST    = 6'd4;
    localparam logic [CNT_W-1:0]   TEMPO_LAST_IDX = 6'd10;
    localparam logic [CNT_W-1:0]   SEARCH_TOP_BIT = 6'd7;
    localparam logic [CNT_W-1:0]   DIV_LAST_STEP  = 6'(NUM_W - 1);

    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_CONTROL  = 8'hB0;
    localparam logic [6:0] VELOCITY    = 7'd100;
    localparam logic [6:0] CC_ATTACK   = 7'd73;
    localparam logic [6:0] CC_DECAY    = 7'd75;
    localparam logic [6:0] CC_SUSTAIN  = 7'd70;
    localparam logic [6:0] CC_RELEASE  = 7'd72;

    // End-of-track meta event followed by the tempo meta event.
    localparam logic [7:0] META_BYTES [0:15] = '{
        8'h00, 8'hFF, 8'h2F, 8'h00,
        8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        VR_FREQ_LO  = 3'd0,
        VR_FREQ_HI  = 3'd1,
        VR_PULSE_LO = 3'd2,
        VR_PULSE_HI = 3'd3,
        VR_CTRL     = 3'd4,
        VR_AD       = 3'd5,
        VR_SR       = 3'd6,
        VR_NONE     = 3'd7
    } t_vreg;

    typedef enum logic [1:0] {
        EV_OFF,
        EV_ON,
        EV_CC_A,
        EV_CC_B
    } t_event;

    typedef enum logic [2:0] {
        BS_DELTA,
        BS_STATUS,
        BS_DATA1,
        BS_DATA2,
        BS_CONST
    } t_bsel;

    typedef enum logic [1:0] {
        MODE_WRITE,
        MODE_STOP,
        MODE_START
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_NMUL,
        S_NSRCH,
        S_NDONE,
        S_TMUL,
        S_TDIV,
        S_TSET,
        S_STOPV,
        S_DPREP,
        S_DELTA,
        S_STAT,
        S_DATA1,
        S_DATA2,
        S_CONST
    } t_state;

    typedef struct packed {
        logic              load;
        logic              wr_latch;
        logic              reg_apply;
        logic              note_mul;
        logic              note_step;
        logic              tick_mul;
        logic              tick_src_last;
        logic              div_step;
        logic              tick_set;
        logic              delta_clr;
        logic              hold_set;
        logic              held_clr;
        logic              stop_apply;
        logic              start_apply;
        logic              emit;
        logic              last;
        t_bsel             bsel;
        t_event            ev;
        logic [CNT_W-1:0]  idx;
        logic [VIDX_W-1:0] voice;
    } t_dp_cmd;

    typedef struct packed {
        logic              recording;
        t_action           action;
        t_vreg             vreg;
        logic [VIDX_W-1:0] addr_voice;
        logic              gate_rise;
        logic              gate_fall;
        logic              held_sel;
        logic              note_ok;
        logic [1:0]        groups_m1;
        logic              out_free;
    } t_dp_sts;

    function automatic logic [EDGE_W-1:0] semitone_edge(input logic [3:0] s);
        logic [EDGE_W-1:0] e;
        case (s)
            4'd0:    e = 28'd133262262;
            4'd1:    e = 28'd141186449;
            4'd2:    e = 28'd149581832;
            4'd3:    e = 28'd158476430;
            4'd4:    e = 28'd167899929;
            4'd5:    e = 28'd177883778;
            4'd6:    e = 28'd188461298;
            4'd7:    e = 28'd199667790;
            4'd8:    e = 28'd211540655;
            4'd9:    e = 28'd224119517;
            4'd10:   e = 28'd237446357;
            4'd11:   e = 28'd251565652;
            default: e = '0;
        endcase
        return e;
    endfunction

    // Lower pitch-product bound of note n: edge of the semitone shifted by the octave.
    function automatic logic [PROD_W-1:0] note_boundary(input logic [7:0] n);
        logic [15:0] m;
        logic [3:0]  oct;
        logic [7:0]  semi;
        m    = {8'd0, n} * 16'd171;
        oct  = m[14:11];
        semi = n - 8'({4'd0, oct} * 8'd12);
        return {{(PROD_W-EDGE_W){1'b0}}, semitone_edge(semi[3:0])} << oct;
    endfunction

endpackage

// ===== src/smid_if.sv =====
// Item channel interfaces for register writes in and track bytes out.
interface smid_in_if import smid_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [4:0]       reg_addr;
    logic [7:0]       reg_value;
    logic [CLK_W-1:0] cpu_clock;

    modport source (output valid, action, reg_addr, reg_value, cpu_clock, input ready);
    modport sink   (input valid, action, reg_addr, reg_value, cpu_clock, output ready);
endinterface

interface smid_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] track_byte;
    logic       last_byte;

    modport source (output valid, track_byte, last_byte, input ready);
    modport sink   (input valid, track_byte, last_byte, output ready);
endinterface

// ===== src/smid_datapath.sv =====
// Datapath: voice state, tick divider, note search, byte assembly and output register.
module smid_datapath import smid_pkg::*; #(
    parameter int VOICE_COUNT = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [RATE_W-1:0] i_clock_rate,
    input  logic [1:0]        i_action,
    input  logic [4:0]        i_reg_addr,
    input  logic [7:0]        i_reg_value,
    input  logic [CLK_W-1:0]  i_cpu_clock,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_track_byte,
    output logic              o_last_byte
);

    t_action              r_action;
    logic [4:0]           r_addr;
    logic [7:0]           r_val;
    logic [CLK_W-1:0]     r_clk;

    logic                 r_recording;
    logic                 r_latched;
    logic [CLK_W-1:0]     r_start;
    logic [CLK_W-1:0]     r_last_write;
    logic [TICK_W-1:0]    r_last_tick;
    logic [15:0]          r_freq       [VOICE_COUNT];
    logic                 r_gate       [VOICE_COUNT];
    logic [6:0]           r_held_note  [VOICE_COUNT];
    logic                 r_held_valid [VOICE_COUNT];

    logic [PROD_W-1:0]    r_prod;
    logic [7:0]           r_scnt;
    logic [NUM_W-1:0]     r_num;
    logic [RATE_W:0]      r_rem;
    logic [DELTA_W-1:0]   r_delta;

    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic [VIDX_W-1:0]    addr_voice;
    t_vreg                vreg;
    logic [15:0]          freq_sel;
    logic                 gate_sel;
    logic [6:0]           held_note_sel;
    logic                 held_valid_sel;
    logic [6:0]           note;
    logic [CLK_W-1:0]     clk_sel;
    logic [CLK_W-1:0]     elapsed;
    logic [NUM_W-1:0]     scaled;
    logic [RATE_W:0]      rem_sh;
    logic                 div_ge;
    logic [7:0]           trial;
    logic                 trial_ok;
    logic [TICK_W-1:0]    ticks;
    logic [TICK_W-1:0]    delta_raw;
    logic [7:0]           byte_val;
    logic                 out_free;

    always_comb begin
        addr_voice = '0;
        vreg       = VR_NONE;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            if (r_addr >= 5'(REGS_PER_VOICE * v) && r_addr < 5'(REGS_PER_VOICE * (v + 1))) begin
                addr_voice = VIDX_W'(v);
                vreg       = t_vreg'(3'(r_addr - 5'(REGS_PER_VOICE * v)));
            end
        end
    end

    always_comb begin
        freq_sel       = '0;
        gate_sel       = 1'b0;
        held_note_sel  = '0;
        held_valid_sel = 1'b0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            if (i_cmd.voice == VIDX_W'(v)) begin
                freq_sel       = r_freq[v];
                gate_sel       = r_gate[v];
                held_note_sel  = r_held_note[v];
                held_valid_sel = r_held_valid[v];
            end
        end
    end

    assign note = 7'(r_scnt - 8'd1);

    // Elapsed cycles times 960, written as times 1024 minus times 64.
    assign clk_sel = i_cmd.tick_src_last ? r_last_write : r_clk;
    assign elapsed = (clk_sel > r_start) ? clk_sel - r_start : '0;
    assign scaled  = (NUM_W'(elapsed) << 10) - (NUM_W'(elapsed) << 6);

    // One restoring division step: the quotient bits shift into r_num behind the dividend.
    assign rem_sh = {r_rem[RATE_W-1:0], r_num[NUM_W-1]};
    assign div_ge = rem_sh >= {1'b0, i_clock_rate};

    assign trial    = r_scnt | (8'd1 << i_cmd.idx[2:0]);
    assign trial_ok = (trial <= NOTE_COUNT_TOP) && (r_prod >= note_boundary(trial - 8'd1));

    assign ticks     = (i_clock_rate == '0) ? '0 :
                       ((|r_num[NUM_W-1:TICK_W]) ? '1 : r_num[TICK_W-1:0]);
    assign delta_raw = (ticks >= r_last_tick) ? ticks - r_last_tick : '0;

    always_comb begin
        byte_val = '0;
        case (i_cmd.bsel)
            BS_DELTA: begin
                case (i_cmd.idx[1:0])
                    2'd0:    byte_val = {1'b0, r_delta[6:0]};
                    2'd1:    byte_val = {1'b1, r_delta[13:7]};
                    2'd2:    byte_val = {1'b1, r_delta[20:14]};
                    default: byte_val = {1'b1, r_delta[27:21]};
                endcase
            end
            BS_STATUS: begin
                case (i_cmd.ev)
                    EV_OFF:  byte_val = ST_NOTE_OFF | {6'd0, i_cmd.voice};
                    EV_ON:   byte_val = ST_NOTE_ON | {6'd0, i_cmd.voice};
                    default: byte_val = ST_CONTROL | {6'd0, i_cmd.voice};
                endcase
            end
            BS_DATA1: begin
                case (i_cmd.ev)
                    EV_OFF:  byte_val = {1'b0, held_note_sel};
                    EV_ON:   byte_val = {1'b0, note};
                    EV_CC_A: byte_val = {1'b0, (vreg == VR_AD) ? CC_ATTACK : CC_SUSTAIN};
                    default: byte_val = {1'b0, (vreg == VR_AD) ? CC_DECAY : CC_RELEASE};
                endcase
            end
            BS_DATA2: begin
                case (i_cmd.ev)
                    EV_OFF:  byte_val = '0;
                    EV_ON:   byte_val = {1'b0, VELOCITY};
                    EV_CC_A: byte_val = {1'b0, r_val[7:4], 3'b111};
                    default: byte_val = {1'b0, r_val[3:0], 3'b111};
                endcase
            end
            BS_CONST: byte_val = META_BYTES[i_cmd.idx[3:0]];
            default:  byte_val = '0;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts            = '0;
        o_sts.recording  = r_recording;
        o_sts.action     = r_action;
        o_sts.vreg       = vreg;
        o_sts.addr_voice = addr_voice;
        o_sts.gate_rise  = (vreg == VR_CTRL) && !gate_sel && r_val[0];
        o_sts.gate_fall  = (vreg == VR_CTRL) && gate_sel && !r_val[0];
        o_sts.held_sel   = held_valid_sel;
        o_sts.note_ok    = (r_scnt != 8'd0) && (r_scnt != NOTE_COUNT_TOP);
        if (r_delta[27:21] != '0) begin
            o_sts.groups_m1 = 2'd3;
        end else if (r_delta[20:14] != '0) begin
            o_sts.groups_m1 = 2'd2;
        end else if (r_delta[13:7] != '0) begin
            o_sts.groups_m1 = 2'd1;
        end else begin
            o_sts.groups_m1 = 2'd0;
        end
        o_sts.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_addr   <= i_reg_addr;
            r_val    <= i_reg_value;
            r_clk    <= i_cpu_clock;
        end
        if (i_cmd.note_mul) begin
            r_prod <= {{(PROD_W-16){1'b0}}, freq_sel} * {{(PROD_W-RATE_W){1'b0}}, i_clock_rate};
            r_scnt <= '0;
        end else if (i_cmd.note_step && trial_ok) begin
            r_scnt <= trial;
        end
        if (i_cmd.tick_mul) begin
            r_num <= scaled;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], div_ge};
            r_rem <= div_ge ? rem_sh - {1'b0, i_clock_rate} : rem_sh;
        end
        if (i_cmd.tick_set) begin
            r_delta <= (delta_raw > TICK_W'(DELTA_MAX)) ? DELTA_MAX : delta_raw[DELTA_W-1:0];
        end else if (i_cmd.delta_clr) begin
            r_delta <= '0;
        end
        if (i_cmd.emit) begin
            r_out_byte <= byte_val;
            r_out_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recording  <= 1'b0;
            r_latched    <= 1'b0;
            r_start      <= '0;
            r_last_write <= '0;
            r_last_tick  <= '0;
            r_out_valid  <= 1'b0;
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_freq[v]       <= '0;
                r_gate[v]       <= 1'b0;
                r_held_note[v]  <= '0;
                r_held_valid[v] <= 1'b0;
            end
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.wr_latch) begin
                if (!r_latched) begin
                    r_start     <= r_clk;
                    r_last_tick <= '0;
                    r_latched   <= 1'b1;
                end
                r_last_write <= r_clk;
            end
            if (i_cmd.tick_set) begin
                r_last_tick <= ticks;
            end
            for (int v = 0; v < VOICE_COUNT; v++) begin
                if (i_cmd.voice == VIDX_W'(v)) begin
                    if (i_cmd.reg_apply) begin
                        case (vreg)
                            VR_FREQ_LO: r_freq[v] <= {r_freq[v][15:8], r_val};
                            VR_FREQ_HI: r_freq[v] <= {r_val, r_freq[v][7:0]};
                            VR_CTRL:    r_gate[v] <= r_val[0];
                            default:    r_freq[v] <= r_freq[v];
                        endcase
                    end
                    if (i_cmd.hold_set) begin
                        r_held_note[v]  <= note;
                        r_held_valid[v] <= 1'b1;
                    end else if (i_cmd.held_clr) begin
                        r_held_valid[v] <= 1'b0;
                    end
                end
            end
            if (i_cmd.stop_apply) begin
                r_recording <= 1'b0;
            end
            if (i_cmd.start_apply) begin
                r_recording  <= 1'b1;
                r_latched    <= 1'b0;
                r_last_tick  <= '0;
                r_last_write <= '0;
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    r_freq[v]       <= '0;
                    r_gate[v]       <= 1'b0;
                    r_held_note[v]  <= '0;
                    r_held_valid[v] <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_track_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

endmodule

// ===== src/smid_ctrl.sv =====
// Controller state machine: sequences decode, arithmetic steps and byte emission.
module smid_ctrl import smid_pkg::*; #(
    parameter int VOICE_COUNT = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [VIDX_W-1:0] LastVoice = VIDX_W'(VOICE_COUNT - 1);

    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    t_event            r_ev, n_ev;
    logic              r_rise, n_rise;
    logic [VIDX_W-1:0] r_voice, n_voice;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_ev    = r_ev;
        n_rise  = r_rise;
        n_voice = r_voice;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_sts.action)
                    ACT_WRITE: begin
                        if (i_sts.recording) begin
                            n_mode  = MODE_WRITE;
                            n_voice = i_sts.addr_voice;
                            n_state = S_WRITE;
                        end
                    end
                    ACT_START: begin
                        n_mode  = MODE_START;
                        n_voice = '0;
                        if (i_sts.recording) begin
                            n_state = S_TMUL;
                        end else begin
                            n_cnt   = TEMPO_FIRST;
                            n_state = S_CONST;
                        end
                    end
                    ACT_STOP: begin
                        if (i_sts.recording) begin
                            n_mode  = MODE_STOP;
                            n_voice = '0;
                            n_state = S_TMUL;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_WRITE: begin
                n_state = S_IDLE;
                case (i_sts.vreg)
                    VR_CTRL: begin
                        if (i_sts.gate_rise) begin
                            n_rise  = 1'b1;
                            n_state = S_NMUL;
                        end else if (i_sts.gate_fall && i_sts.held_sel) begin
                            n_rise  = 1'b0;
                            n_ev    = EV_OFF;
                            n_state = S_TMUL;
                        end
                    end
                    VR_AD, VR_SR: begin
                        n_ev    = EV_CC_A;
                        n_state = S_TMUL;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_NMUL: begin
                n_cnt   = SEARCH_TOP_BIT;
                n_state = S_NSRCH;
            end
            S_NSRCH: begin
                if (r_cnt == '0) begin
                    n_state = S_NDONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_NDONE: begin
                if (i_sts.note_ok) begin
                    n_ev    = i_sts.held_sel ? EV_OFF : EV_ON;
                    n_state = S_TMUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TMUL: begin
                n_cnt   = DIV_LAST_STEP;
                n_state = S_TDIV;
            end
            S_TDIV: begin
                if (r_cnt == '0) begin
                    n_state = S_TSET;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_TSET: begin
                n_state = (r_mode == MODE_WRITE) ? S_DPREP : S_STOPV;
            end
            S_STOPV: begin
                n_ev = EV_OFF;
                if (i_sts.held_sel) begin
                    n_state = S_DPREP;
                end else if (r_voice == LastVoice) begin
                    n_cnt   = '0;
                    n_state = S_CONST;
                end else begin
                    n_voice = r_voice + VIDX_W'(1);
                end
            end
            S_DPREP: begin
                n_cnt   = CNT_W'(i_sts.groups_m1);
                n_state = S_DELTA;
            end
            S_DELTA: begin
                if (i_sts.out_free) begin
                    if (r_cnt == '0) begin
                        n_state = S_STAT;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    n_state = S_DATA1;
                end
            end
            S_DATA1: begin
                if (i_sts.out_free) begin
                    n_state = S_DATA2;
                end
            end
            S_DATA2: begin
                if (i_sts.out_free) begin
                    if (r_mode != MODE_WRITE) begin
                        if (r_voice == LastVoice) begin
                            n_cnt   = '0;
                            n_state = S_CONST;
                        end else begin
                            n_voice = r_voice + VIDX_W'(1);
                            n_state = S_STOPV;
                        end
                    end else begin
                        n_state = S_IDLE;
                        case (r_ev)
                            EV_OFF: begin
                                if (r_rise) begin
                                    n_ev    = EV_ON;
                                    n_state = S_DPREP;
                                end
                            end
                            EV_CC_A: begin
                                n_ev    = EV_CC_B;
                                n_state = S_DPREP;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_CONST: begin
                if (i_sts.out_free) begin
                    if ((r_cnt == END_LAST_IDX && r_mode == MODE_STOP) ||
                        r_cnt == TEMPO_LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd               = '0;
        o_cmd.bsel          = BS_DELTA;
        o_cmd.ev            = r_ev;
        o_cmd.idx           = r_cnt;
        o_cmd.voice         = r_voice;
        o_cmd.tick_src_last = (r_mode != MODE_WRITE);
        o_in_ready          = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: o_cmd.wr_latch  = (i_sts.action == ACT_WRITE) && i_sts.recording;
            S_WRITE:  o_cmd.reg_apply = 1'b1;
            S_NMUL:   o_cmd.note_mul  = 1'b1;
            S_NSRCH:  o_cmd.note_step = 1'b1;
            S_TMUL:   o_cmd.tick_mul  = 1'b1;
            S_TDIV:   o_cmd.div_step  = 1'b1;
            S_TSET:   o_cmd.tick_set  = 1'b1;
            S_DELTA: begin
                o_cmd.bsel = BS_DELTA;
                o_cmd.emit = i_sts.out_free;
            end
            S_STAT: begin
                o_cmd.bsel = BS_STATUS;
                o_cmd.emit = i_sts.out_free;
            end
            S_DATA1: begin
                o_cmd.bsel = BS_DATA1;
                o_cmd.emit = i_sts.out_free;
            end
            S_DATA2: begin
                o_cmd.bsel      = BS_DATA2;
                o_cmd.emit      = i_sts.out_free;
                o_cmd.delta_clr = i_sts.out_free;
                o_cmd.last      = (r_mode == MODE_WRITE) &&
                                  (r_ev == EV_ON || r_ev == EV_CC_B || (r_ev == EV_OFF && !r_rise));
                o_cmd.hold_set  = i_sts.out_free && r_mode == MODE_WRITE && r_ev == EV_ON;
                // A note-off ahead of a new note-on leaves the held slot to the note-on.
                o_cmd.held_clr  = i_sts.out_free && r_ev == EV_OFF &&
                                  !(r_mode == MODE_WRITE && r_rise);
            end
            S_CONST: begin
                o_cmd.bsel        = BS_CONST;
                o_cmd.emit        = i_sts.out_free;
                o_cmd.last        = (r_cnt == END_LAST_IDX && r_mode == MODE_STOP) ||
                                    r_cnt == TEMPO_LAST_IDX;
                o_cmd.stop_apply  = i_sts.out_free && r_cnt == END_LAST_IDX;
                o_cmd.start_apply = i_sts.out_free && r_cnt == TEMPO_LAST_IDX;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_WRITE;
            r_ev    <= EV_OFF;
            r_rise  <= 1'b0;
            r_voice <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_ev    <= n_ev;
            r_rise  <= n_rise;
            r_voice <= n_voice;
            r_cnt   <= n_cnt;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("byte emitted while output register is occupied");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == S_DECODE)
        else $error("accepted item not decoded");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && o_cmd.last |=> r_state == S_IDLE)
        else $error("final byte not followed by idle");

    a_single_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.hold_set && o_cmd.held_clr))
        else $error("held note set and cleared together");

endmodule

// ===== src/sid_writes_to_midi_events.sv =====
// Top level: configuration register, controller and datapath of the chip-write to MIDI block.
// Sequence: after a register write is accepted, the tick count is formed by one tick
//   division step per quotient bit (58 steps), preceded by the 8-step note search when a
//   gate rise needs a note; a start command that is not recording emits its meta bytes directly.
// Flow: one item at a time; the next item is accepted once the previous item's last
//   byte is in the output register, or once an ignored item has been decoded; output
//   stalls can hold this back.
// Reset: synchronous, active low; clears recording, voice and timing state and sets
//   clock_rate to 985248.
module sid_writes_to_midi_events import smid_pkg::*; #(
    parameter int VOICE_COUNT = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smid_in_if.sink      i_in,
    smid_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [RATE_W-1:0] r_clock_rate;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-RATE_W){1'b0}}, r_clock_rate} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= RATE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_clock_rate <= pwdata[RATE_W-1:0];
        end
    end

    smid_ctrl #(
        .VOICE_COUNT(VOICE_COUNT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    smid_datapath #(
        .VOICE_COUNT(VOICE_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_clock_rate(r_clock_rate),
        .i_action    (i_in.action),
        .i_reg_addr  (i_in.reg_addr),
        .i_reg_value (i_in.reg_value),
        .i_cpu_clock (i_in.cpu_clock),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_track_byte(o_out.track_byte),
        .o_last_byte (o_out.last_byte)
    );

endmodule
